// ===== rtl/kmp_pkg.sv =====
// kmp_pkg: shared constants, input kind codes and controller/datapath types
// for the kmp pattern match counter; no dependencies
`default_nettype none

package kmp_pkg;

  localparam int unsigned KindW        = 2;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CountW       = 20;
  localparam int unsigned MaxPatDefault = 64;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // input item kinds
  localparam logic [KindW-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KindW-1:0] KIND_APPEND = 2'd1;
  localparam logic [KindW-1:0] KIND_TEXT   = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clear_pat;     // empty the pattern
    logic start_append;  // store pattern byte, start failure walk at build position
    logic start_text;    // latch text byte, start failure walk at match position
    logic walk_step;     // follow one failure link
    logic app_finish;    // write new failure entry, grow pattern
    logic advance;       // step past a matched byte, count a full match
    logic fail_take;     // take failure link of the full pattern after a match
    logic emit;          // load the result register
  } kmp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic walk_done;     // position negative or pattern byte equals current byte
    logic pat_full;      // no room for another pattern byte
    logic hit_next;      // next position equals pattern length
    logic len_zero;      // empty pattern
    logic out_free;      // result register can take a new result
  } kmp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/kmp_if.sv =====
// kmp_in_if and kmp_out_if: valid/ready channels for input items and results
// depends on kmp_pkg for field widths
`default_nettype none

interface kmp_in_if;
  logic                          valid;
  logic                          ready;
  logic [kmp_pkg::KindW-1:0]     kind;
  logic [kmp_pkg::ByteW-1:0]     byte_value;
  logic                          last_text;

  modport source (output valid, output kind, output byte_value, output last_text,
                  input ready);
  modport sink   (input valid, input kind, input byte_value, input last_text,
                  output ready);
endinterface

interface kmp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          match_end;
  logic [kmp_pkg::CountW-1:0]    match_count;
  logic                          text_done;

  modport source (output valid, output match_end, output match_count,
                  output text_done, input ready);
  modport sink   (input valid, input match_end, input match_count,
                  input text_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/kmp_ctrl.sv =====
// kmp_ctrl: state machine sequencing pattern append and text match walks
// depends on kmp_pkg for kind codes and command/status structs
`default_nettype none

module kmp_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [kmp_pkg::KindW-1:0] in_kind_i,
  output logic                           in_ready_o,
  input  wire kmp_pkg::kmp_sts_t         sts_i,
  output kmp_pkg::kmp_cmd_t              cmd_o
);
  import kmp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRD   = 3'd1;  // memory read in flight
  localparam logic [2:0] ST_WCMP  = 3'd2;  // compare or follow failure link
  localparam logic [2:0] ST_FRD   = 3'd3;  // read failure entry of full pattern
  localparam logic [2:0] ST_FTAKE = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;  // wait for free result register

  logic [2:0] state_q, state_d;
  logic       text_q, text_d;

  always_comb begin
    state_d    = state_q;
    text_d     = text_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_kind_i)
            KIND_CLEAR: begin
              cmd_o.clear_pat = 1'b1;
            end
            KIND_APPEND: begin
              if (!sts_i.pat_full) begin
                cmd_o.start_append = 1'b1;
                text_d             = 1'b0;
                state_d            = ST_WRD;
              end
            end
            KIND_TEXT: begin
              cmd_o.start_text = 1'b1;
              text_d           = 1'b1;
              state_d          = ST_WRD;
            end
            default: ;
          endcase
        end
      end
      ST_WRD: begin
        state_d = ST_WCMP;
      end
      ST_WCMP: begin
        if (!sts_i.walk_done) begin
          cmd_o.walk_step = 1'b1;
          state_d         = ST_WRD;
        end else if (!text_q) begin
          cmd_o.app_finish = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = (sts_i.hit_next && !sts_i.len_zero) ? ST_FRD : ST_EMIT;
        end
      end
      ST_FRD: begin
        state_d = ST_FTAKE;
      end
      ST_FTAKE: begin
        cmd_o.fail_take = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      text_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      text_q  <= text_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kmp_dp.sv =====
// kmp_dp: pattern and failure memories, position registers, count and result register
// depends on kmp_pkg for widths and command/status structs
`default_nettype none

module kmp_dp #(
  parameter int unsigned MaxPat = kmp_pkg::MaxPatDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire kmp_pkg::kmp_cmd_t          cmd_i,
  output kmp_pkg::kmp_sts_t               sts_o,
  input  wire logic [kmp_pkg::ByteW-1:0]  in_byte_i,
  input  wire logic                       in_last_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic                            out_match_end_o,
  output logic [kmp_pkg::CountW-1:0]      out_match_count_o,
  output logic                            out_text_done_o
);
  import kmp_pkg::*;

  localparam int unsigned LenW  = $clog2(MaxPat + 1);
  localparam int unsigned PosW  = LenW + 1;
  localparam int unsigned AddrW = (MaxPat > 1) ? $clog2(MaxPat) : 1;

  localparam logic signed [PosW-1:0] PosNone = '1;  // minus one

  // pattern bytes and failure links of entries 1..MaxPat (entry 0 is always minus one)
  logic [ByteW-1:0] pat_mem  [MaxPat];
  logic [AddrW-1:0] fail_mem [MaxPat];

  logic [ByteW-1:0] pat_rdata_q;
  logic [AddrW-1:0] fail_rdata_q;

  logic [LenW-1:0]        len_q, len_d;
  logic signed [PosW-1:0] bp_q, bp_d;     // build position
  logic signed [PosW-1:0] mp_q, mp_d;     // match position
  logic signed [PosW-1:0] j_q, j_d;       // working position
  logic [ByteW-1:0]       byte_q;
  logic                   last_q;
  logic                   hit_q;
  logic [CountW-1:0]      count_q, count_d;

  logic                   out_valid_q;
  logic                   out_end_q;
  logic [CountW-1:0]      out_count_q;
  logic                   out_done_q;

  logic signed [PosW-1:0] len_s;
  logic signed [PosW-1:0] j_inc;
  logic signed [PosW-1:0] j_dec;
  logic signed [PosW-1:0] fail_link;
  logic                   hit_next;

  assign len_s     = $signed({1'b0, len_q});
  assign j_inc     = j_q + PosW'(1);
  assign j_dec     = j_q - PosW'(1);
  assign fail_link = $signed({{(PosW-AddrW){1'b0}}, fail_rdata_q});
  assign hit_next  = (j_inc == len_s);

  assign sts_o.walk_done = j_q[PosW-1] || ((j_q < len_s) && (pat_rdata_q == byte_q));
  assign sts_o.pat_full  = (len_q == LenW'(MaxPat));
  assign sts_o.hit_next  = hit_next;
  assign sts_o.len_zero  = (len_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // memories: one write port, registered reads addressed by the working position
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_append) begin
      pat_mem[len_q[AddrW-1:0]] <= in_byte_i;
    end
    if (cmd_i.app_finish) begin
      fail_mem[len_q[AddrW-1:0]] <= j_inc[AddrW-1:0];
    end
    pat_rdata_q  <= pat_mem[j_q[AddrW-1:0]];
    fail_rdata_q <= fail_mem[j_dec[AddrW-1:0]];
  end

  always_comb begin
    len_d   = len_q;
    bp_d    = bp_q;
    mp_d    = mp_q;
    j_d     = j_q;
    count_d = count_q;
    if (cmd_i.clear_pat) begin
      len_d = '0;
      bp_d  = PosNone;
      mp_d  = '0;
    end
    if (cmd_i.start_append) begin
      j_d = bp_q;
    end
    if (cmd_i.start_text) begin
      j_d = (mp_q > len_s) ? '0 : mp_q;
    end
    if (cmd_i.walk_step) begin
      j_d = (j_q == '0) ? PosNone : fail_link;
    end
    if (cmd_i.app_finish) begin
      len_d = len_q + LenW'(1);
      bp_d  = j_inc;
      mp_d  = '0;
    end
    if (cmd_i.advance) begin
      j_d = (hit_next && (len_q == '0)) ? PosNone : j_inc;
      if (hit_next && (count_q != CountMax)) begin
        count_d = count_q + CountW'(1);
      end
    end
    if (cmd_i.fail_take) begin
      j_d = fail_link;
    end
    if (cmd_i.emit) begin
      mp_d    = last_q ? '0 : j_q;
      count_d = last_q ? '0 : count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      bp_q        <= PosNone;
      mp_q        <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      bp_q        <= bp_d;
      mp_q        <= mp_d;
      count_q     <= count_d;
      out_valid_q <= cmd_i.emit || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    if (cmd_i.start_append || cmd_i.start_text) begin
      byte_q <= in_byte_i;
    end
    if (cmd_i.start_text) begin
      last_q <= in_last_i;
    end
    if (cmd_i.advance) begin
      hit_q <= hit_next;
    end
    if (cmd_i.emit) begin
      out_end_q   <= hit_q;
      out_count_q <= count_q;
      out_done_q  <= last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_match_end_o   = out_end_q;
  assign out_match_count_o = out_count_q;
  assign out_text_done_o   = out_done_q;

endmodule

`default_nettype wire

// ===== rtl/kmp_pattern_match_counter.sv =====
// kmp_pattern_match_counter: top level, kmp matcher counting overlapping occurrences
// depends on kmp_pkg, kmp_if, kmp_ctrl and kmp_dp
`default_nettype none

// channel  | dir | modport | transfer carries
// ---------+-----+---------+------------------------------------------------
// in_i     | in  | sink    | kind, byte_value, last_text (one input item)
// out_o    | out | source  | match_end, match_count, text_done (one result)
//
// clear and unused kinds finish in idle, as does a pattern byte that finds the
// pattern full; a pattern byte then takes a memory read and a compare, and a
// text byte also the emit state, plus a read and take of the full pattern's
// failure entry when a full match ends at it; each failure link followed adds
// a registered read of the pattern and failure memories, then a compare
// failure walks amortise to at most one link per byte over a long stream
// reset clears pattern length, build and match positions, count and the result
// valid flag; memories need no clearing, entries are written before being read
// a held result does not block the next item; the block stalls only when a
// new result is ready and the previous one has not been taken

module kmp_pattern_match_counter #(
  parameter int unsigned MaxPat = kmp_pkg::MaxPatDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kmp_in_if.sink     in_i,
  kmp_out_if.source  out_o
);
  import kmp_pkg::*;

  kmp_cmd_t cmd;   // controller commands
  kmp_sts_t sts;   // datapath status
  logic     in_ready;

  // sequencer: accepts items in idle only, steps the failure walk
  kmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // memories, positions, saturating count and the result register
  kmp_dp #(
    .MaxPat (MaxPat)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_byte_i         (in_i.byte_value),
    .in_last_i         (in_i.last_text),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_match_end_o   (out_o.match_end),
    .out_match_count_o (out_o.match_count),
    .out_text_done_o   (out_o.text_done)
  );

endmodule

`default_nettype wire
